@@ rtl/lpcs_pkg.sv @@
// shared types and constants for the latch-up power-cycle sequencer
`default_nettype none

package lpcs_pkg;

    // channel count and register geometry
    localparam int NCH     = 3;
    localparam int DATA_W  = 16;
    localparam int IDX_W   = 3;
    localparam int PHASE_W = 2;

    // parameter defaults
    localparam int TIME_UNIT_DEF = 100;
    localparam int MS_DIVIDE_DEF = 10;

    // register indexes
    localparam logic [IDX_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_HOLD_CH1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_HOLD_CH2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_HOLD_CH3 = 3'd3;
    localparam logic [IDX_W-1:0] REG_OFF_CH1  = 3'd4;
    localparam logic [IDX_W-1:0] REG_OFF_CH2  = 3'd5;
    localparam logic [IDX_W-1:0] REG_OFF_CH3  = 3'd6;

    // input request payload
    typedef struct packed {
        logic hold_req_ch1;
        logic hold_req_ch2;
        logic hold_req_ch3;
    } in_t;

    // result payload
    typedef struct packed {
        logic               cut_ch1;
        logic               cut_ch2;
        logic               cut_ch3;
        logic [PHASE_W-1:0] phase_ch1;
        logic [PHASE_W-1:0] phase_ch2;
        logic [PHASE_W-1:0] phase_ch3;
        logic               debug_level;
        logic               tick_1ms;
        logic               tick_half;
    } out_t;

    // debug pin write from one channel
    typedef struct packed {
        logic wr;
        logic val;
    } dbg_t;

endpackage

`default_nettype wire

@@ rtl/lpcs_cfg.sv @@
// configuration registers with dwell limits precomputed at write time
`default_nettype none

module lpcs_cfg #(
    parameter int TIME_UNIT = lpcs_pkg::TIME_UNIT_DEF,
    parameter int CNT_W     = 11
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [lpcs_pkg::IDX_W-1:0]            cfg_index,
    input  wire logic [lpcs_pkg::DATA_W-1:0]           cfg_data,
    output logic      [lpcs_pkg::NCH-1:0]              enable_mask,
    output logic      [lpcs_pkg::NCH-1:0][CNT_W-1:0]   hold_lim,
    output logic      [lpcs_pkg::NCH-1:0][CNT_W-1:0]   off_lim
);

    // reciprocal for exact floor division of a 16 bit value by the tick length
    localparam int SHIFT = lpcs_pkg::DATA_W + $clog2(TIME_UNIT);
    localparam logic [lpcs_pkg::DATA_W:0] RECIP =
        (lpcs_pkg::DATA_W + 1)'(((64'd1 << SHIFT) + 64'(TIME_UNIT) - 64'd1) / 64'(TIME_UNIT));
    localparam int PROD_W = 2 * lpcs_pkg::DATA_W + 1;

    logic [PROD_W-1:0]                      prod;
    logic [lpcs_pkg::DATA_W-1:0]            quot;
    logic [CNT_W-1:0]                       hold_val;
    logic [CNT_W-1:0]                       off_val;
    logic [lpcs_pkg::NCH-1:0]               enable_reg;
    logic [lpcs_pkg::NCH-1:0][CNT_W-1:0]    hold_reg;
    logic [lpcs_pkg::NCH-1:0][CNT_W-1:0]    off_reg;

    // ticks in the written duration, then half of it for hold and twice for off
    assign prod     = PROD_W'(cfg_data) * PROD_W'(RECIP);
    assign quot     = lpcs_pkg::DATA_W'(prod >> SHIFT);
    assign hold_val = CNT_W'(quot >> 1);
    assign off_val  = CNT_W'({quot, 1'b0});

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
            hold_reg   <= '0;
            off_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lpcs_pkg::REG_ENABLE:   enable_reg  <= cfg_data[lpcs_pkg::NCH-1:0];
                lpcs_pkg::REG_HOLD_CH1: hold_reg[0] <= hold_val;
                lpcs_pkg::REG_HOLD_CH2: hold_reg[1] <= hold_val;
                lpcs_pkg::REG_HOLD_CH3: hold_reg[2] <= hold_val;
                lpcs_pkg::REG_OFF_CH1:  off_reg[0]  <= off_val;
                lpcs_pkg::REG_OFF_CH2:  off_reg[1]  <= off_val;
                lpcs_pkg::REG_OFF_CH3:  off_reg[2]  <= off_val;
                default:                ;
            endcase
        end
    end

    assign enable_mask = enable_reg;
    assign hold_lim    = hold_reg;
    assign off_lim     = off_reg;

endmodule

`default_nettype wire

@@ rtl/lpcs_chan.sv @@
// one channel's idle, hold, off sequencer with its dwell counter
`default_nettype none

module lpcs_chan #(
    parameter int CNT_W = 11
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           run,
    input  wire logic                           req,
    input  wire logic [CNT_W-1:0]               hold_lim,
    input  wire logic [CNT_W-1:0]               off_lim,
    output logic      [lpcs_pkg::PHASE_W-1:0]   phase,
    output logic                                cut,
    output lpcs_pkg::dbg_t                      dbg
);

    typedef enum logic [lpcs_pkg::PHASE_W-1:0] {
        PH_IDLE = 2'd0,
        PH_HOLD = 2'd1,
        PH_OFF  = 2'd2
    } phase_t;

    phase_t             phase_reg;
    phase_t             phase_next;
    phase_t             ph_eff;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   cnt_eff;
    logic               cut_reg;
    logic               cut_next;

    // request start, then one tick of the current phase
    always_comb
    begin
        ph_eff     = phase_reg;
        cnt_eff    = cnt_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        cut_next   = cut_reg;
        dbg        = '0;
        if (req && phase_reg == PH_IDLE)
        begin
            ph_eff  = PH_HOLD;
            cnt_eff = '0;
        end
        if (run)
        begin
            unique case (ph_eff)
                PH_HOLD:
                begin
                    dbg.wr = 1'b1;
                    if (cnt_eff <= hold_lim)
                    begin
                        phase_next = PH_HOLD;
                        cnt_next   = cnt_eff + CNT_W'(1);
                        cut_next   = 1'b0;
                        dbg.val    = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_OFF;
                        cnt_next   = '0;
                        cut_next   = 1'b1;
                        dbg.val    = 1'b0;
                    end
                end
                PH_OFF:
                begin
                    if (cnt_eff <= off_lim)
                    begin
                        cnt_next = cnt_eff + CNT_W'(1);
                        cut_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        cnt_next   = '0;
                        cut_next   = 1'b0;
                    end
                end
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            cut_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            cut_reg   <= cut_next;
        end
    end

    assign phase = phase_next;
    assign cut   = cut_next;

endmodule

`default_nettype wire

@@ rtl/latchup_power_cycle_sequencer.sv @@
// top level of the three-channel latch-up power-cycle sequencer
`default_nettype none

// One request is one timer tick carrying a hold request per channel, and each
// request yields exactly one result with the cut lines, phases, debug level and
// tick flags after that tick. The block takes one request per clock cycle
// while the output is not stalled; a request is held in the input register
// and its result is then registered in the output register. The output
// register is separate from the input register, so a new request is taken
// while a finished result waits on out_stall. Dwell limits are computed from
// the duration registers by a constant-reciprocal multiply when the register
// is written, so a tick itself costs only a compare and an increment.

module latchup_power_cycle_sequencer #(
    parameter int TIME_UNIT = lpcs_pkg::TIME_UNIT_DEF,
    parameter int MS_DIVIDE = lpcs_pkg::MS_DIVIDE_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [lpcs_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [lpcs_pkg::DATA_W-1:0]    cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire lpcs_pkg::in_t                  in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output lpcs_pkg::out_t                      out_data
);

    // dwell count must reach twice the longest off time plus one
    localparam int CNT_W = $clog2(2 * ((1 << lpcs_pkg::DATA_W) - 1) / TIME_UNIT + 2);
    localparam int MSD_W = $clog2(MS_DIVIDE);

    localparam int NCH = lpcs_pkg::NCH;

    logic [NCH-1:0]                 enable_mask;
    logic [NCH-1:0][CNT_W-1:0]      hold_lim;
    logic [NCH-1:0][CNT_W-1:0]      off_lim;
    logic [NCH-1:0]                 req;
    logic [NCH-1:0]                 run;
    logic [NCH-1:0]                 cut;
    logic [NCH-1:0][lpcs_pkg::PHASE_W-1:0] phase;
    lpcs_pkg::dbg_t [NCH-1:0]       dbg;

    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    lpcs_pkg::in_t                  s1_data_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    lpcs_pkg::out_t                 out_data_reg;
    lpcs_pkg::out_t                 out_data_next;
    logic                           debug_reg;
    logic                           debug_next;
    logic [MSD_W-1:0]               msdiv_reg;
    logic [MSD_W-1:0]               msdiv_next;
    logic                           ms_flag_reg;
    logic                           ms_flag_next;
    logic                           half_reg;
    logic                           half_next;
    logic                           out_free;
    logic                           process;
    logic                           accept;

    // configuration registers
    lpcs_cfg #(
        .TIME_UNIT (TIME_UNIT),
        .CNT_W     (CNT_W)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .enable_mask (enable_mask),
        .hold_lim    (hold_lim),
        .off_lim     (off_lim)
    );

    // handshake and pipeline advance
    assign out_free = !out_valid_reg || !out_stall;
    assign process  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    assign req = {s1_data_reg.hold_req_ch3, s1_data_reg.hold_req_ch2,
                  s1_data_reg.hold_req_ch1};
    assign run = enable_mask & {NCH{process}};

    // channel sequencers
    for (genvar c = 0; c < NCH; c++)
    begin : g_chan
        lpcs_chan #(
            .CNT_W (CNT_W)
        ) u_chan (
            .clk      (clk),
            .rst_n    (rst_n),
            .run      (run[c]),
            .req      (req[c]),
            .hold_lim (hold_lim[c]),
            .off_lim  (off_lim[c]),
            .phase    (phase[c]),
            .cut      (cut[c]),
            .dbg      (dbg[c])
        );
    end

    // shared debug pin, highest channel written this tick wins
    always_comb
    begin
        debug_next = debug_reg;
        priority if (dbg[2].wr)
            debug_next = dbg[2].val;
        else if (dbg[1].wr)
            debug_next = dbg[1].val;
        else if (dbg[0].wr)
            debug_next = dbg[0].val;
        else
            debug_next = debug_reg;
    end

    // millisecond divider and toggle flag
    always_comb
    begin
        msdiv_next   = msdiv_reg;
        ms_flag_next = ms_flag_reg;
        half_next    = half_reg;
        if (process)
        begin
            if (msdiv_reg <= MSD_W'(MS_DIVIDE - 2))
            begin
                msdiv_next   = msdiv_reg + MSD_W'(1);
                ms_flag_next = 1'b0;
            end
            else
            begin
                msdiv_next   = '0;
                ms_flag_next = 1'b1;
            end
            half_next = !half_reg;
        end
    end

    // result assembly
    always_comb
    begin
        out_data_next             = out_data_reg;
        out_data_next.cut_ch1     = cut[0];
        out_data_next.cut_ch2     = cut[1];
        out_data_next.cut_ch3     = cut[2];
        out_data_next.phase_ch1   = phase[0];
        out_data_next.phase_ch2   = phase[1];
        out_data_next.phase_ch3   = phase[2];
        out_data_next.debug_level = debug_next;
        out_data_next.tick_1ms    = ms_flag_next;
        out_data_next.tick_half   = half_next;
    end

    // valid flags of both stages
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (process)
            s1_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (process)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    // control and tick state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            debug_reg     <= 1'b0;
            msdiv_reg     <= '0;
            ms_flag_reg   <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            debug_reg     <= debug_next;
            msdiv_reg     <= msdiv_next;
            ms_flag_reg   <= ms_flag_next;
            half_reg      <= half_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_data_reg <= in_data;
        if (process)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
